@@ src/ibd_pkg.sv @@
package ibd_pkg;

	localparam int MAX_PLANE_BYTES = 64;
	localparam int MAX_PLANES      = 8;
	localparam int COL_W           = $clog2(MAX_PLANE_BYTES);
	localparam int PL_W            = $clog2(MAX_PLANES);
	localparam int ADDR_W          = COL_W + PL_W;
	localparam int GRP_W           = COL_W + 1;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic [1:0] {
		CFG_WIDTH      = 2'd0,
		CFG_HEIGHT     = 2'd1,
		CFG_PLANES     = 2'd2,
		CFG_COMPRESSED = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       image_start;
	} in_req_t;

	typedef struct packed {
		logic [7:0] pixel_a;
		logic [7:0] pixel_b;
		logic [7:0] pixel_c;
		logic [7:0] pixel_d;
		logic [7:0] pixel_e;
		logic [7:0] pixel_f;
		logic [7:0] pixel_g;
		logic [7:0] pixel_h;
		logic [3:0] pixels_valid;
		logic       row_end;
		logic       image_end;
	} out_req_t;

	typedef struct packed {
		logic [9:0]  width;
		logic [15:0] height;
		logic [3:0]  planes;
		logic        compressed;
	} cfg_t;

	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic              emit;
		logic [GRP_W-1:0]  groups;
		logic [9:0]        width;
		logic [3:0]        planes;
		logic              last_row;
	} cmd_t;

endpackage

@@ src/ibd_queue.sv @@
module ibd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ibd_pkg::cmd_t wr_data,
	output logic          q_full,
	input  logic          rd_en,
	output ibd_pkg::cmd_t rd_data,
	output logic          q_empty
);
	import ibd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign q_full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !q_full) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !q_full) wp_q <= wp_q + 1'b1;
			if (rd_en && !q_empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr_en && !q_full) - (PW+1)'(rd_en && !q_empty);
		end
	end
endmodule

@@ src/ibd_front.sv @@
module ibd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  ibd_pkg::cfg_t    cfg,
	input  logic             push,
	output logic             full,
	input  ibd_pkg::in_req_t item,
	output logic             cmd_push,
	output ibd_pkg::cmd_t    cmd,
	input  logic             q_full
);
	import ibd_pkg::*;

	typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT, PH_SKIP} phase_t;
	typedef enum logic {ST_TAKE, ST_RUN} state_t;

	state_t          st_q, st_d;
	phase_t          phase_q, phase_e, phase_d;
	logic [7:0]      lit_q, lit_e, lit_d, rep_q, rep_d, run_byte_q, run_byte_d;
	logic [PL_W-1:0] plane_q, plane_e, plane_n, plane_d;
	logic [COL_W:0]  col_q, col_e, col_n, col_d, col_inc, pb;
	logic [15:0]     rows_q, rows_e, rows_d;
	logic [9:0]      w_eff;
	logic [3:0]      np_eff, pl_inc;
	logic            take, start, put, stores, ended, row_done;

	always_comb begin
		w_eff = cfg.width;
		if (w_eff == '0) w_eff = 10'd1;
		if (w_eff > 10'(MAX_PLANE_BYTES * 8)) w_eff = 10'(MAX_PLANE_BYTES * 8);
		np_eff = cfg.planes;
		if (np_eff == '0) np_eff = 4'd1;
		if (np_eff > 4'(MAX_PLANES)) np_eff = 4'(MAX_PLANES);
		pb = 7'((w_eff + 10'd7) >> 3);
		pb = pb + {6'd0, pb[0]};
		if (pb > 7'(MAX_PLANE_BYTES)) pb = 7'(MAX_PLANE_BYTES);
	end

	assign full  = (st_q != ST_TAKE) || q_full;
	assign take  = push && !full;
	assign start = (st_q == ST_TAKE) && item.image_start;

	assign phase_e = start ? PH_HEADER : phase_q;
	assign lit_e   = start ? 8'd0 : lit_q;
	assign plane_e = start ? '0 : plane_q;
	assign col_e   = start ? '0 : col_q;
	assign rows_e  = start ? 16'd0 : rows_q;

	always_comb begin
		col_inc  = col_e + 1'b1;
		pl_inc   = 4'(plane_e) + 4'd1;
		stores   = (4'(plane_e) < np_eff) && (col_e < pb);
		ended    = !((col_inc < pb) && (4'(plane_e) < np_eff));
		row_done = ended && (pl_inc >= np_eff);
		plane_n  = ended ? (row_done ? '0 : pl_inc[PL_W-1:0]) : plane_e;
		col_n    = ended ? '0 : col_inc;
	end

	always_comb begin
		put = 1'b0;
		if (st_q == ST_RUN) begin
			put = !q_full;
		end else if (take && rows_e < cfg.height) begin
			put = !cfg.compressed || phase_e == PH_LITERAL;
		end
	end

	assign cmd_push     = put;
	assign cmd.wr       = stores;
	assign cmd.addr     = {plane_e, col_e[COL_W-1:0]};
	assign cmd.data     = (st_q == ST_RUN) ? run_byte_q : item.body_byte;
	assign cmd.emit     = row_done;
	assign cmd.groups   = GRP_W'((w_eff + 10'd7) >> 3);
	assign cmd.width    = w_eff;
	assign cmd.planes   = np_eff;
	assign cmd.last_row = (17'(rows_e) + 17'd1) == 17'(cfg.height);

	always_comb begin
		st_d       = st_q;
		phase_d    = phase_q;
		lit_d      = lit_q;
		rep_d      = rep_q;
		plane_d    = plane_q;
		col_d      = col_q;
		rows_d     = rows_q;
		run_byte_d = run_byte_q;
		if (st_q == ST_RUN) begin
			if (!q_full) begin
				plane_d = plane_n;
				col_d   = col_n;
				if (row_done) rows_d = rows_q + 16'd1;
				if (ended || rep_q == 8'd1) begin
					rep_d   = '0;
					phase_d = PH_HEADER;
					st_d    = ST_TAKE;
				end else begin
					rep_d = rep_q - 8'd1;
				end
			end
		end else if (take) begin
			phase_d = phase_e;
			lit_d   = lit_e;
			plane_d = plane_e;
			col_d   = col_e;
			rows_d  = rows_e;
			if (start) rep_d = '0;
			if (rows_e < cfg.height) begin
				if (put) begin
					plane_d = plane_n;
					col_d   = col_n;
					if (row_done) rows_d = rows_e + 16'd1;
				end
				if (!cfg.compressed) begin
					phase_d = PH_HEADER;
					lit_d   = '0;
					rep_d   = '0;
				end else begin
					unique case (phase_e)
						PH_HEADER: begin
							if (item.body_byte > 8'h80) begin
								rep_d   = 8'(9'd257 - 9'(item.body_byte));
								phase_d = PH_REPEAT;
							end else if (item.body_byte < 8'h80) begin
								lit_d   = item.body_byte + 8'd1;
								phase_d = PH_LITERAL;
							end
						end
						PH_LITERAL: begin
							lit_d = lit_e - 8'd1;
							if (lit_e == 8'd1) phase_d = PH_HEADER;
							else if (ended) phase_d = PH_SKIP;
						end
						PH_REPEAT: begin
							run_byte_d = item.body_byte;
							st_d       = ST_RUN;
						end
						PH_SKIP: begin
							lit_d = lit_e - 8'd1;
							if (lit_e == 8'd1) phase_d = PH_HEADER;
						end
						default: phase_d = PH_HEADER;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_TAKE;
			phase_q    <= PH_HEADER;
			lit_q      <= '0;
			rep_q      <= '0;
			plane_q    <= '0;
			col_q      <= '0;
			rows_q     <= '0;
			run_byte_q <= '0;
		end else begin
			st_q       <= st_d;
			phase_q    <= phase_d;
			lit_q      <= lit_d;
			rep_q      <= rep_d;
			plane_q    <= plane_d;
			col_q      <= col_d;
			rows_q     <= rows_d;
			run_byte_q <= run_byte_d;
		end
	end
endmodule

@@ src/ibd_back.sv @@
module ibd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ibd_pkg::cmd_t     cmd,
	input  logic              q_empty,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output ibd_pkg::out_req_t result
);
	import ibd_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_READ, B_DRAIN, B_HOLD} state_t;

	state_t            st_q;
	logic [7:0]        mem [MAX_PLANES*MAX_PLANE_BYTES];
	logic [7:0]        rdata_q;
	logic              rv_q;
	logic [PL_W-1:0]   rpl_q, pl_q;
	logic [GRP_W-1:0]  g_q, groups_q;
	logic [9:0]        width_q, rem;
	logic [3:0]        planes_q, valid;
	logic              last_q, ov_q, load;
	logic [7:0][7:0]   acc_q;
	logic [7:0][7:0]   pix;
	out_req_t          out_q;

	assign cmd_pop = (st_q == B_IDLE) && !q_empty;
	assign empty   = !ov_q;
	assign result  = out_q;
	assign load    = (st_q == B_HOLD) && (!ov_q || pop);

	always_comb begin
		rem   = width_q - {1'b0, g_q[COL_W-1:0], 3'd0};
		valid = (rem >= 10'd8) ? 4'd8 : rem[3:0];
		for (int p = 0; p < 8; p++) begin
			pix[p] = (4'(p) < valid) ? acc_q[p] : 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.wr) mem[cmd.addr] <= cmd.data;
		rdata_q <= mem[{pl_q, g_q[COL_W-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			rv_q     <= 1'b0;
			rpl_q    <= '0;
			pl_q     <= '0;
			g_q      <= '0;
			groups_q <= '0;
			width_q  <= '0;
			planes_q <= '0;
			last_q   <= 1'b0;
			ov_q     <= 1'b0;
			acc_q    <= '0;
			out_q    <= '0;
		end else begin
			rv_q  <= (st_q == B_READ);
			rpl_q <= pl_q;
			if (rv_q) begin
				for (int p = 0; p < 8; p++) acc_q[p][rpl_q] <= rdata_q[7-p];
			end
			if (load) ov_q <= 1'b1;
			else if (pop && ov_q) ov_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (cmd_pop && cmd.emit) begin
						groups_q <= cmd.groups;
						width_q  <= cmd.width;
						planes_q <= cmd.planes;
						last_q   <= cmd.last_row;
						g_q      <= '0;
						pl_q     <= '0;
						acc_q    <= '0;
						st_q     <= B_READ;
					end
				end
				B_READ: begin
					if (4'(pl_q) + 4'd1 >= planes_q) st_q <= B_DRAIN;
					else pl_q <= pl_q + 1'b1;
				end
				B_DRAIN: st_q <= B_HOLD;
				B_HOLD: begin
					if (load) begin
						out_q.pixel_a      <= pix[0];
						out_q.pixel_b      <= pix[1];
						out_q.pixel_c      <= pix[2];
						out_q.pixel_d      <= pix[3];
						out_q.pixel_e      <= pix[4];
						out_q.pixel_f      <= pix[5];
						out_q.pixel_g      <= pix[6];
						out_q.pixel_h      <= pix[7];
						out_q.pixels_valid <= valid;
						out_q.row_end      <= (g_q + 1'b1 == groups_q);
						out_q.image_end    <= (g_q + 1'b1 == groups_q) && last_q;
						acc_q              <= '0;
						pl_q               <= '0;
						g_q                <= g_q + 1'b1;
						st_q <= (g_q + 1'b1 == groups_q) ? B_IDLE : B_READ;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

@@ src/ilbm_byterun_planar_decoder_core.sv @@
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------
// input    | push / full           | item   (body_byte, image_start)
// result   | empty / pop           | result (pixel_a..h, valid, ends)
// config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Bytes are accepted one a cycle while the command queue has room and no
// repeat run is being played out; the front decoder holds full during a run.
// A row flush reads the row store once per plane per group through the single
// store read port, then passes the B_DRAIN and B_HOLD states per result group.
// Reset clears all control state; the row store holds no reset value.
// A stalled result consumer backs up the flush, the queue, then full.
module ilbm_byterun_planar_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  ibd_pkg::in_req_t  item,
	output logic              empty,
	input  logic              pop,
	output ibd_pkg::out_req_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import ibd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width      <= 10'd320;
			cfg_q.height     <= 16'd200;
			cfg_q.planes     <= 4'd8;
			cfg_q.compressed <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:      cfg_q.width      <= cfg_data[9:0];
				CFG_HEIGHT:     cfg_q.height     <= cfg_data;
				CFG_PLANES:     cfg_q.planes     <= cfg_data[3:0];
				CFG_COMPRESSED: cfg_q.compressed <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ibd_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .push(push), .full(full),
		.item(item), .cmd_push(cmd_push), .cmd(cmd_in), .q_full(q_full)
	);

	ibd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(cmd_push), .wr_data(cmd_in),
		.q_full(q_full), .rd_en(cmd_pop), .rd_data(cmd_out), .q_empty(q_empty)
	);

	ibd_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_out), .q_empty(q_empty),
		.cmd_pop(cmd_pop), .empty(empty), .pop(pop), .result(result)
	);
endmodule
